// ----- hw/rtl/mbrfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrfc_pkg
// Types, codes and the CRC-16/MODBUS byte update used by the reply frame
// checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbrfc_pkg;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_CRC   = 2'd2,
    ST_EXC   = 2'd3
  } frame_status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_EXPECTED_FUNCTION = 2'd0,
    REG_CRC_CHECK_ENABLE  = 2'd1,
    REG_ECHO_SKIP_LENGTH  = 2'd2,
    REG_UNUSED            = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [8:0]  COUNT_MAX = 9'd511;

  localparam logic [7:0]  RST_EXPECTED_FUNCTION = 8'd3;
  localparam logic        RST_CRC_CHECK_ENABLE  = 1'b1;
  localparam logic [7:0]  RST_ECHO_SKIP_LENGTH  = 8'd0;

  // Feed one byte into a reflected CRC-16 (8 shift steps)
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mbrfc_in_if.sv -----
// ----------------------------------------------------------------------------
// mbrfc_in_if
// Byte channel into the reply frame checker: valid/ready with one received
// byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/mbrfc_out_if.sv -----
// ----------------------------------------------------------------------------
// mbrfc_out_if
// Result channel of the reply frame checker: valid/ready with the frame
// status, answer length and exception code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbrfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [8:0] answer_length;
  logic [7:0] exception_code;

  modport source (output valid, output frame_status, output answer_length,
                  output exception_code, input ready);
  modport sink   (input valid, input frame_status, input answer_length,
                  input exception_code, output ready);
endinterface

// ----- hw/rtl/modbus_response_frame_checker_top.sv -----
// ----------------------------------------------------------------------------
// modbus_response_frame_checker_top
// Checks a received Modbus reply byte by byte: skips echoed query bytes,
// tracks CRC-16/MODBUS over the answer and reports one status per frame.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake      Payload
//   in_bus    in    valid/ready    data_byte[7:0], last_byte
//   out_bus   out   valid/ready    frame_status[1:0], answer_length[8:0],
//                                  exception_code[7:0]
//   cfg_*     in    cfg_we         cfg_index[1:0], cfg_data[7:0]
//
// One byte per cycle: the CRC byte update and frame bookkeeping are done in
// the accept cycle; the status is registered on the last byte's accept and
// is shown in the cycle after it. in_bus.ready drops only while a result is
// held and out_bus is stalled. Synchronous active-low reset restores register
// defaults and an empty frame; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_response_frame_checker_top
  import mbrfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  mbrfc_in_if.sink         in_bus,
  mbrfc_out_if.source      out_bus,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  // Configuration registers
  logic [7:0]  exp_func_r;
  logic        crc_en_r;
  logic [7:0]  skip_len_r;

  // Frame state
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_tail_r, crc_tail_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        in_ans_r, in_ans_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  third_r, third_nxt;
  logic [15:0] last2_r, last2_nxt;

  // Output register
  logic          out_valid_r;
  frame_status_t status_r, status_nxt;
  logic [8:0]    len_r, len_nxt;
  logic [7:0]    code_r, code_nxt;

  logic        in_acc;
  logic        skipping;
  logic [8:0]  c;
  logic [8:0]  n;
  logic        crc_bad;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_func_r <= RST_EXPECTED_FUNCTION;
      crc_en_r   <= RST_CRC_CHECK_ENABLE;
      skip_len_r <= RST_ECHO_SKIP_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EXPECTED_FUNCTION: exp_func_r <= cfg_data;
        REG_CRC_CHECK_ENABLE:  crc_en_r   <= cfg_data[0];
        REG_ECHO_SKIP_LENGTH:  skip_len_r <= cfg_data;
        REG_UNUSED:            ;
      endcase
    end
  end

  // Advance frame state for one item and build its status
  always_comb begin
    crc_nxt      = crc_r;
    crc_tail_nxt = crc_tail_r;
    cnt_nxt      = cnt_r;
    in_ans_nxt   = in_ans_r;
    func_nxt     = func_r;
    third_nxt    = third_r;
    last2_nxt    = last2_r;

    skipping = !in_ans_r && (cnt_r < {1'b0, skip_len_r});
    c        = in_ans_r ? cnt_r : 9'd0;

    if (skipping) begin
      cnt_nxt = cnt_r + 9'd1;
    end else begin
      in_ans_nxt = 1'b1;
      if (c != 9'd0) begin
        crc_tail_nxt = crc_r;
        crc_nxt      = crc_feed(crc_r, last2_r[7:0]);
      end
      last2_nxt = {last2_r[7:0], in_bus.data_byte};
      if (c == 9'd1) func_nxt  = in_bus.data_byte;
      if (c == 9'd2) third_nxt = in_bus.data_byte;
      cnt_nxt = (c < COUNT_MAX) ? c + 9'd1 : c;
    end

    n       = in_ans_nxt ? cnt_nxt : 9'd0;
    crc_bad = crc_en_r && ((crc_tail_nxt[7:0] != last2_nxt[15:8]) ||
                           (crc_tail_nxt[15:8] != last2_nxt[7:0]));

    status_nxt = ST_OK;
    len_nxt    = 9'd0;
    code_nxt   = 8'd0;
    priority if (n < 9'd2) begin
      status_nxt = ST_SHORT;
    end else if (crc_bad) begin
      status_nxt = ST_CRC;
    end else if (func_nxt != exp_func_r) begin
      status_nxt = ST_EXC;
      len_nxt    = n;
      code_nxt   = (n >= 9'd3) ? third_nxt : 8'd0;
    end else begin
      len_nxt    = n;
    end
  end

  // Hold frame state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      crc_tail_r <= CRC_INIT;
      cnt_r      <= 9'd0;
      in_ans_r   <= 1'b0;
      func_r     <= 8'd0;
      third_r    <= 8'd0;
      last2_r    <= 16'd0;
    end else if (in_acc) begin
      if (in_bus.last_byte) begin
        crc_r      <= CRC_INIT;
        crc_tail_r <= CRC_INIT;
        cnt_r      <= 9'd0;
        in_ans_r   <= 1'b0;
        func_r     <= 8'd0;
        third_r    <= 8'd0;
        last2_r    <= 16'd0;
      end else begin
        crc_r      <= crc_nxt;
        crc_tail_r <= crc_tail_nxt;
        cnt_r      <= cnt_nxt;
        in_ans_r   <= in_ans_nxt;
        func_r     <= func_nxt;
        third_r    <= third_nxt;
        last2_r    <= last2_nxt;
      end
    end
  end

  // Load the result on the last byte; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_bus.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_bus.last_byte) begin
      status_r <= status_nxt;
      len_r    <= len_nxt;
      code_r   <= code_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.frame_status   = status_r;
  assign out_bus.answer_length  = len_r;
  assign out_bus.exception_code = code_r;

`ifndef NO_ASSERTIONS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus.last_byte) |=> out_bus.valid)
    else $error("last byte accepted without a result");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus.last_byte) |=> (cnt_r == 9'd0 && !in_ans_r && crc_r == CRC_INIT))
    else $error("frame state not cleared after last byte");

  a_code_only_exc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.frame_status != ST_EXC) |-> (out_bus.exception_code == 8'd0))
    else $error("exception code set on a non-exception status");

  a_len_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.frame_status == ST_SHORT || out_bus.frame_status == ST_CRC))
      |-> (out_bus.answer_length == 9'd0))
    else $error("answer length set on a failed frame");
`endif

endmodule
